[rtl/core/wfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall follow sequencer package
// Types, codes and reset values shared by the sequencer, its step logic and
// its checker.
// ----------------------------------------------------------------------------
package wfs_pkg;

   localparam int unsigned DataWidth   = 16;
   localparam int unsigned StepWidth   = 5;
   localparam int unsigned ActWidth    = 3;
   localparam int unsigned StatWidth   = 2;
   localparam int unsigned CsrIdxWidth = 4;

   localparam logic [DataWidth-1:0] FRONT_TURN_RATE = 16'd40;

   typedef enum logic [ActWidth-1:0] {
      ACT_NONE = 3'd0,
      ACT_STOP = 3'd1,
      ACT_CW   = 3'd2,
      ACT_CCW  = 3'd3,
      ACT_FWD  = 3'd4
   } action_type;

   typedef enum logic [StatWidth-1:0] {
      STAT_RUNNING = 2'd0,
      STAT_DOCKED  = 2'd1,
      STAT_LOST    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CLS_AWAY = 2'd0,
      CLS_NEAR = 2'd1,
      CLS_FAR  = 2'd2,
      CLS_SAFE = 2'd3
   } class_type;

   typedef enum logic [StepWidth-1:0] {
      STEP_START          = 5'd0,
      STEP_CHECK_FLOOR    = 5'd1,
      STEP_DOCK           = 5'd2,
      STEP_CHECK_FR       = 5'd3,
      STEP_CHECK_FL       = 5'd4,
      STEP_FRONT_CW_A     = 5'd5,
      STEP_FRONT_CW_B     = 5'd6,
      STEP_CHECK_LT       = 5'd7,
      STEP_CHECK_LB_A     = 5'd8,
      STEP_CHECK_LB_B     = 5'd9,
      STEP_SEARCH_WALL    = 5'd10,
      STEP_CW_SLOW        = 5'd11,
      STEP_CW_FAST        = 5'd12,
      STEP_CCW_SLOW       = 5'd13,
      STEP_CCW_FAST       = 5'd14,
      STEP_FWD_SLOW       = 5'd15,
      STEP_FWD_FAST       = 5'd16
   } step_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_FRONT_NEAR = 4'd0,
      REG_FRONT_FAR  = 4'd1,
      REG_SIDE_NEAR  = 4'd2,
      REG_SIDE_FAR   = 4'd3,
      REG_SLOW_SPEED = 4'd4,
      REG_FAST_SPEED = 4'd5,
      REG_SLOW_TURN  = 4'd6,
      REG_FAST_TURN  = 4'd7
   } reg_index_type;

   localparam logic [DataWidth-1:0] FRONT_NEAR_RESET = 16'd20000;
   localparam logic [DataWidth-1:0] FRONT_FAR_RESET  = 16'd5000;
   localparam logic [DataWidth-1:0] SIDE_NEAR_RESET  = 16'd20000;
   localparam logic [DataWidth-1:0] SIDE_FAR_RESET   = 16'd5000;
   localparam logic [DataWidth-1:0] SLOW_SPEED_RESET = 16'd50;
   localparam logic [DataWidth-1:0] FAST_SPEED_RESET = 16'd100;
   localparam logic [DataWidth-1:0] SLOW_TURN_RESET  = 16'd10;
   localparam logic [DataWidth-1:0] FAST_TURN_RESET  = 16'd30;

   typedef struct packed {
      logic [DataWidth-1:0] front_near_level;
      logic [DataWidth-1:0] front_far_level;
      logic [DataWidth-1:0] side_near_level;
      logic [DataWidth-1:0] side_far_level;
      logic [DataWidth-1:0] slow_speed;
      logic [DataWidth-1:0] fast_speed;
      logic [DataWidth-1:0] slow_turn;
      logic [DataWidth-1:0] fast_turn;
   } cfg_type;

   typedef struct packed {
      logic [DataWidth-1:0] prox_front_right;
      logic [DataWidth-1:0] prox_front_left;
      logic [DataWidth-1:0] prox_left_top;
      logic [DataWidth-1:0] prox_left_bottom;
      logic                 floor_left_black;
      logic                 floor_right_black;
   } item_type;

   typedef struct packed {
      step_type             next_step;
      status_type           next_status;
      action_type           action;
      logic [DataWidth-1:0] amount;
      step_type             step_number;
   } result_type;

   function automatic class_type classify(input logic [DataWidth-1:0] v,
                                          input logic [DataWidth-1:0] near_lvl,
                                          input logic [DataWidth-1:0] far_lvl);
      class_type c;
      if (v == '0) begin
         c = CLS_AWAY;
      end else if (v > near_lvl) begin
         c = CLS_NEAR;
      end else if (v < far_lvl) begin
         c = CLS_FAR;
      end else begin
         c = CLS_SAFE;
      end
      return c;
   endfunction

endpackage

[rtl/core/wall_follow_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall follow sequencer
// Seventeen-step wall-following sequencer with dock detection; one motor
// command per control tick.
// ----------------------------------------------------------------------------
// Takes one tick per clock cycle while req_stall is low and returns one
// result per tick. The tick is held in the input register; the step logic
// then writes the result register and the step state in the same cycle, so
// the rate is set by that step update. A waiting result holds the
// next tick in the input register, so the input stalls only while both the
// input and the result register are full. The eight setting registers are
// written via the csr_ port, one per cycle; the user must write them only while
// no tick is in flight (not enforced here); indexes above seven are ignored.
module wall_follow_sequencer
   import wfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [DataWidth-1:0]   req_prox_front_right,
   input  logic [DataWidth-1:0]   req_prox_front_left,
   input  logic [DataWidth-1:0]   req_prox_left_top,
   input  logic [DataWidth-1:0]   req_prox_left_bottom,
   input  logic                   req_floor_left_black,
   input  logic                   req_floor_right_black,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ActWidth-1:0]    rsp_motor_action,
   output logic [DataWidth-1:0]   rsp_motor_amount,
   output logic [StatWidth-1:0]   rsp_run_status,
   output logic [StepWidth-1:0]   rsp_step_number,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]   csr_wdata
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   item_type   item_ff;
   item_type   item_in;
   logic       item_valid_ff;
   logic       item_valid_in;
   step_type   step_ff;
   step_type   step_in;
   status_type status_ff;
   status_type status_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type rsp_in;
   result_type res;
   logic       req_take;
   logic       advance;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FRONT_NEAR: cfg_in.front_near_level = csr_wdata;
            REG_FRONT_FAR:  cfg_in.front_far_level  = csr_wdata;
            REG_SIDE_NEAR:  cfg_in.side_near_level  = csr_wdata;
            REG_SIDE_FAR:   cfg_in.side_far_level   = csr_wdata;
            REG_SLOW_SPEED: cfg_in.slow_speed       = csr_wdata;
            REG_FAST_SPEED: cfg_in.fast_speed       = csr_wdata;
            REG_SLOW_TURN:  cfg_in.slow_turn        = csr_wdata;
            REG_FAST_TURN:  cfg_in.fast_turn        = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   wfs_step u_step (
      .cfg        (cfg_ff),
      .item       (item_ff),
      .cur_step   (step_ff),
      .cur_status (status_ff),
      .res        (res)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in.prox_front_right  = req_prox_front_right;
      item_in.prox_front_left   = req_prox_front_left;
      item_in.prox_left_top     = req_prox_left_top;
      item_in.prox_left_bottom  = req_prox_left_bottom;
      item_in.floor_left_black  = req_floor_left_black;
      item_in.floor_right_black = req_floor_right_black;
      item_valid_in = req_take || (item_valid_ff && !advance);
      rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);
      rsp_in        = advance ? res : rsp_ff;
      step_in       = advance ? res.next_step : step_ff;
      status_in     = advance ? res.next_status : status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_near_level <= FRONT_NEAR_RESET;
         cfg_ff.front_far_level  <= FRONT_FAR_RESET;
         cfg_ff.side_near_level  <= SIDE_NEAR_RESET;
         cfg_ff.side_far_level   <= SIDE_FAR_RESET;
         cfg_ff.slow_speed       <= SLOW_SPEED_RESET;
         cfg_ff.fast_speed       <= FAST_SPEED_RESET;
         cfg_ff.slow_turn        <= SLOW_TURN_RESET;
         cfg_ff.fast_turn        <= FAST_TURN_RESET;
         item_valid_ff           <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         step_ff                 <= STEP_START;
         status_ff               <= STAT_RUNNING;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
         status_ff     <= status_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motor_action = rsp_ff.action;
   assign rsp_motor_amount = rsp_ff.amount;
   assign rsp_run_status   = rsp_ff.next_status;
   assign rsp_step_number  = rsp_ff.step_number;

endmodule

[rtl/core/wfs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall follow step logic
// Runs the current step on one tick: classifies readings, picks the motor
// command and the next step, and holds a finished run.
// ----------------------------------------------------------------------------
module wfs_step
   import wfs_pkg::*;
(
   input  cfg_type    cfg,
   input  item_type   item,
   input  step_type   cur_step,
   input  status_type cur_status,
   output result_type res
);

   class_type cls_fr;
   class_type cls_fl;
   class_type cls_lt;
   class_type cls_lb;
   step_type  next_step;
   step_type  eff_step;
   action_type           act;
   logic [DataWidth-1:0] amt;
   status_type           status_next;

   assign cls_fr = classify(item.prox_front_right, cfg.front_near_level, cfg.front_far_level);
   assign cls_fl = classify(item.prox_front_left, cfg.front_near_level, cfg.front_far_level);
   assign cls_lt = classify(item.prox_left_top, cfg.side_near_level, cfg.side_far_level);
   assign cls_lb = classify(item.prox_left_bottom, cfg.side_near_level, cfg.side_far_level);

   // next step
   always_comb begin
      next_step = cur_step;
      unique case (cur_step)
         STEP_START:       next_step = STEP_CHECK_FLOOR;
         STEP_CHECK_FLOOR: next_step = (item.floor_left_black || item.floor_right_black) ?
                                       STEP_DOCK : STEP_CHECK_FR;
         STEP_DOCK:        next_step = STEP_DOCK;
         STEP_CHECK_FR:    next_step = (cls_fr == CLS_NEAR) ? STEP_FRONT_CW_A : STEP_CHECK_FL;
         STEP_CHECK_FL:    next_step = (cls_fl == CLS_NEAR) ? STEP_FRONT_CW_B : STEP_CHECK_LT;
         STEP_FRONT_CW_A:  next_step = STEP_CHECK_FR;
         STEP_FRONT_CW_B:  next_step = STEP_CHECK_FL;
         STEP_CHECK_LT: begin
            case (cls_lt)
               CLS_AWAY: next_step = STEP_CHECK_LB_A;
               CLS_NEAR: next_step = STEP_CW_SLOW;
               CLS_FAR:  next_step = STEP_CCW_SLOW;
               default:  next_step = STEP_CHECK_LB_B;
            endcase
         end
         STEP_CHECK_LB_A:  next_step = (cls_lb == CLS_AWAY) ? STEP_SEARCH_WALL : STEP_CCW_FAST;
         STEP_CHECK_LB_B: begin
            case (cls_lb)
               CLS_AWAY, CLS_FAR: next_step = STEP_CW_SLOW;
               CLS_NEAR:          next_step = STEP_CCW_SLOW;
               default:           next_step = STEP_FWD_FAST;
            endcase
         end
         STEP_SEARCH_WALL: next_step = STEP_SEARCH_WALL;
         STEP_CW_SLOW:     next_step = STEP_FWD_SLOW;
         STEP_CW_FAST:     next_step = STEP_FWD_FAST;
         STEP_CCW_SLOW:    next_step = STEP_FWD_SLOW;
         STEP_CCW_FAST:    next_step = STEP_FWD_FAST;
         STEP_FWD_SLOW:    next_step = STEP_CHECK_FLOOR;
         STEP_FWD_FAST:    next_step = STEP_CHECK_FLOOR;
         default:          next_step = STEP_CHECK_FLOOR;
      endcase
      if (cur_status != STAT_RUNNING) begin
         next_step = cur_step;
      end
   end

   // outputs
   always_comb begin
      eff_step    = cur_step;
      act         = ACT_NONE;
      amt         = '0;
      status_next = cur_status;
      unique case (cur_step)
         STEP_DOCK: begin
            act         = ACT_STOP;
            status_next = STAT_DOCKED;
         end
         STEP_FRONT_CW_A, STEP_FRONT_CW_B: begin
            act = ACT_CW;
            amt = FRONT_TURN_RATE;
         end
         STEP_SEARCH_WALL: begin
            act         = ACT_STOP;
            status_next = STAT_LOST;
         end
         STEP_CW_SLOW: begin
            act = ACT_CW;
            amt = cfg.slow_turn;
         end
         STEP_CW_FAST: begin
            act = ACT_CW;
            amt = cfg.fast_turn;
         end
         STEP_CCW_SLOW: begin
            act = ACT_CCW;
            amt = cfg.slow_turn;
         end
         STEP_CCW_FAST: begin
            act = ACT_CCW;
            amt = cfg.fast_turn;
         end
         STEP_FWD_SLOW: begin
            act = ACT_FWD;
            amt = cfg.slow_speed;
         end
         STEP_FWD_FAST: begin
            act = ACT_FWD;
            amt = cfg.fast_speed;
         end
         STEP_START, STEP_CHECK_FLOOR, STEP_CHECK_FR, STEP_CHECK_FL,
         STEP_CHECK_LT, STEP_CHECK_LB_A, STEP_CHECK_LB_B: begin
            act = ACT_NONE;
         end
         default: begin
            // out of range: behave as start
            eff_step = STEP_START;
         end
      endcase
      if (cur_status != STAT_RUNNING) begin
         act         = ACT_STOP;
         amt         = '0;
         status_next = cur_status;
      end
   end

   assign res.next_step   = next_step;
   assign res.next_status = status_next;
   assign res.action      = act;
   assign res.amount      = amt;
   assign res.step_number = eff_step;

endmodule

[rtl/core/wfs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall follow sequencer checker
// Port-level properties of the sequencer's result channel, bound to the top
// level.
// ----------------------------------------------------------------------------
module wfs_checker
   import wfs_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [ActWidth-1:0]  rsp_motor_action,
   input logic [DataWidth-1:0] rsp_motor_amount,
   input logic [StatWidth-1:0] rsp_run_status,
   input logic [StepWidth-1:0] rsp_step_number
);

   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && !rsp_stall;

   a_finished_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_run_status != STAT_RUNNING) |->
         (rsp_motor_action == ACT_STOP) && (rsp_motor_amount == '0))
      else $error("finished run must give stop with zero amount");

   a_status_step: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |->
         ((rsp_run_status == STAT_DOCKED) && (rsp_step_number == STEP_DOCK)) ||
         ((rsp_run_status == STAT_LOST) && (rsp_step_number == STEP_SEARCH_WALL)) ||
         (rsp_run_status == STAT_RUNNING))
      else $error("run status does not match its final step");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_motor_action == ACT_NONE) |->
         (rsp_motor_amount == '0) && (rsp_run_status == STAT_RUNNING))
      else $error("check step must give zero amount while running");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_motor_action) && $stable(rsp_motor_amount) &&
         $stable(rsp_run_status) && $stable(rsp_step_number))
      else $error("stalled result transfer changed");

endmodule

bind wall_follow_sequencer wfs_checker u_wfs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_motor_action (rsp_motor_action),
   .rsp_motor_amount (rsp_motor_amount),
   .rsp_run_status   (rsp_run_status),
   .rsp_step_number  (rsp_step_number)
);

[bench/wall_follow_sequencer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall follow sequencer test
// Drives control ticks through the sequencer under several threshold and
// speed settings and with random gaps on ticks and stalls on results. A step
// tracker follows the step table tick by tick and matches every motor
// command against its own prediction. The run closes by steering the robot
// into either a dock or a lost wall and checking the stop commands after it.
// ----------------------------------------------------------------------------
module wall_follow_sequencer_test;
   import wfs_pkg::*;

   localparam int unsigned IDLE_LIMIT    = 4000;
   localparam int unsigned ROAM_TICKS    = 250;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef enum int unsigned {
      GOAL_ROAM,
      GOAL_DOCK,
      GOAL_LOST
   } goal_type;

   typedef enum int unsigned {
      SET_ZERO,
      SET_FULL,
      SET_RANDOM,
      SET_CROSSED
   } setting_type;

   typedef struct packed {
      action_type           action;
      logic [DataWidth-1:0] amount;
      status_type           status;
      step_type             step;
   } command_type;

   class tick_tracker;
      cfg_type     cfg;
      step_type    cur_step;
      status_type  finished;
      command_type pending[$];
      int unsigned faults;

      function new();
         cfg.front_near_level = FRONT_NEAR_RESET;
         cfg.front_far_level  = FRONT_FAR_RESET;
         cfg.side_near_level  = SIDE_NEAR_RESET;
         cfg.side_far_level   = SIDE_FAR_RESET;
         cfg.slow_speed       = SLOW_SPEED_RESET;
         cfg.fast_speed       = FAST_SPEED_RESET;
         cfg.slow_turn        = SLOW_TURN_RESET;
         cfg.fast_turn        = FAST_TURN_RESET;
         cur_step = STEP_START;
         finished = STAT_RUNNING;
         faults   = 0;
      endfunction

      function void set_reg(logic [CsrIdxWidth-1:0] idx, logic [DataWidth-1:0] val);
         case (idx)
            REG_FRONT_NEAR: cfg.front_near_level = val;
            REG_FRONT_FAR:  cfg.front_far_level  = val;
            REG_SIDE_NEAR:  cfg.side_near_level  = val;
            REG_SIDE_FAR:   cfg.side_far_level   = val;
            REG_SLOW_SPEED: cfg.slow_speed       = val;
            REG_FAST_SPEED: cfg.fast_speed       = val;
            REG_SLOW_TURN:  cfg.slow_turn        = val;
            REG_FAST_TURN:  cfg.fast_turn        = val;
            default: ;
         endcase
      endfunction

      function class_type grade(logic [DataWidth-1:0] v, logic [DataWidth-1:0] near_lvl,
                                logic [DataWidth-1:0] far_lvl);
         if (v == 0)
            return CLS_AWAY;
         if (v > near_lvl)
            return CLS_NEAR;
         if (v < far_lvl)
            return CLS_FAR;
         return CLS_SAFE;
      endfunction

      function void take_tick(item_type t);
         command_type c;
         step_type    nxt;
         class_type   k;
         c.action = ACT_NONE;
         c.amount = '0;
         c.step   = cur_step;
         nxt      = cur_step;
         if (finished != STAT_RUNNING) begin
            c.action = ACT_STOP;
            c.status = finished;
            pending.push_back(c);
            return;
         end
         case (cur_step)
            STEP_START: nxt = STEP_CHECK_FLOOR;
            STEP_CHECK_FLOOR: begin
               if (t.floor_left_black || t.floor_right_black)
                  nxt = STEP_DOCK;
               else
                  nxt = STEP_CHECK_FR;
            end
            STEP_DOCK: begin
               c.action = ACT_STOP;
               finished = STAT_DOCKED;
            end
            STEP_CHECK_FR: begin
               k = grade(t.prox_front_right, cfg.front_near_level, cfg.front_far_level);
               if (k == CLS_NEAR)
                  nxt = STEP_FRONT_CW_A;
               else
                  nxt = STEP_CHECK_FL;
            end
            STEP_CHECK_FL: begin
               k = grade(t.prox_front_left, cfg.front_near_level, cfg.front_far_level);
               if (k == CLS_NEAR)
                  nxt = STEP_FRONT_CW_B;
               else
                  nxt = STEP_CHECK_LT;
            end
            STEP_FRONT_CW_A: begin
               c.action = ACT_CW;
               c.amount = FRONT_TURN_RATE;
               nxt      = STEP_CHECK_FR;
            end
            STEP_FRONT_CW_B: begin
               c.action = ACT_CW;
               c.amount = FRONT_TURN_RATE;
               nxt      = STEP_CHECK_FL;
            end
            STEP_CHECK_LT: begin
               k = grade(t.prox_left_top, cfg.side_near_level, cfg.side_far_level);
               case (k)
                  CLS_AWAY: nxt = STEP_CHECK_LB_A;
                  CLS_NEAR: nxt = STEP_CW_SLOW;
                  CLS_FAR:  nxt = STEP_CCW_SLOW;
                  default:  nxt = STEP_CHECK_LB_B;
               endcase
            end
            STEP_CHECK_LB_A: begin
               k = grade(t.prox_left_bottom, cfg.side_near_level, cfg.side_far_level);
               if (k == CLS_AWAY)
                  nxt = STEP_SEARCH_WALL;
               else
                  nxt = STEP_CCW_FAST;
            end
            STEP_CHECK_LB_B: begin
               k = grade(t.prox_left_bottom, cfg.side_near_level, cfg.side_far_level);
               case (k)
                  CLS_AWAY, CLS_FAR: nxt = STEP_CW_SLOW;
                  CLS_NEAR:          nxt = STEP_CCW_SLOW;
                  default:           nxt = STEP_FWD_FAST;
               endcase
            end
            STEP_SEARCH_WALL: begin
               c.action = ACT_STOP;
               finished = STAT_LOST;
            end
            STEP_CW_SLOW: begin
               c.action = ACT_CW;
               c.amount = cfg.slow_turn;
               nxt      = STEP_FWD_SLOW;
            end
            STEP_CW_FAST: begin
               c.action = ACT_CW;
               c.amount = cfg.fast_turn;
               nxt      = STEP_FWD_FAST;
            end
            STEP_CCW_SLOW: begin
               c.action = ACT_CCW;
               c.amount = cfg.slow_turn;
               nxt      = STEP_FWD_SLOW;
            end
            STEP_CCW_FAST: begin
               c.action = ACT_CCW;
               c.amount = cfg.fast_turn;
               nxt      = STEP_FWD_FAST;
            end
            STEP_FWD_SLOW: begin
               c.action = ACT_FWD;
               c.amount = cfg.slow_speed;
               nxt      = STEP_CHECK_FLOOR;
            end
            default: begin
               c.action = ACT_FWD;
               c.amount = cfg.fast_speed;
               nxt      = STEP_CHECK_FLOOR;
            end
         endcase
         c.status = finished;
         cur_step = nxt;
         pending.push_back(c);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            faults++;
         end
      endfunction

      function void match_command(logic [ActWidth-1:0] action, logic [DataWidth-1:0] amount,
                                  logic [StatWidth-1:0] status, logic [StepWidth-1:0] step);
         command_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected motor command, expected none, actual action %0d step %0d",
                     $time, action, step);
            faults++;
            return;
         end
         want = pending.pop_front();
         compare_field("motor_action", 32'(want.action), 32'(action));
         compare_field("motor_amount", 32'(want.amount), 32'(amount));
         compare_field("run_status", 32'(want.status), 32'(status));
         compare_field("step_number", 32'(want.step), 32'(step));
      endfunction

      function void close();
         if (pending.size() != 0) begin
            $display("%0t: %0d motor commands never arrived, expected 0, actual %0d",
                     $time, pending.size(), pending.size());
            faults++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [DataWidth-1:0]   req_prox_front_right = '0;
   logic [DataWidth-1:0]   req_prox_front_left = '0;
   logic [DataWidth-1:0]   req_prox_left_top = '0;
   logic [DataWidth-1:0]   req_prox_left_bottom = '0;
   logic                   req_floor_left_black = 1'b0;
   logic                   req_floor_right_black = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ActWidth-1:0]    rsp_motor_action;
   logic [DataWidth-1:0]   rsp_motor_amount;
   logic [StatWidth-1:0]   rsp_run_status;
   logic [StepWidth-1:0]   rsp_step_number;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [DataWidth-1:0]   csr_wdata = '0;

   tick_tracker tracker;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned quiet_cycles = 0;

   wall_follow_sequencer u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_prox_front_right  (req_prox_front_right),
      .req_prox_front_left   (req_prox_front_left),
      .req_prox_left_top     (req_prox_left_top),
      .req_prox_left_bottom  (req_prox_left_bottom),
      .req_floor_left_black  (req_floor_left_black),
      .req_floor_right_black (req_floor_right_black),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_motor_action      (rsp_motor_action),
      .rsp_motor_amount      (rsp_motor_amount),
      .rsp_run_status        (rsp_run_status),
      .rsp_step_number       (rsp_step_number),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.match_command(rsp_motor_action, rsp_motor_amount, rsp_run_status,
                               rsp_step_number);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input item_type t);
      while ($urandom_range(99, 0) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_prox_front_right  <= t.prox_front_right;
      req_prox_front_left   <= t.prox_front_left;
      req_prox_left_top     <= t.prox_left_top;
      req_prox_left_bottom  <= t.prox_left_bottom;
      req_floor_left_black  <= t.floor_left_black;
      req_floor_right_black <= t.floor_right_black;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_tick(t);
   endtask

   task automatic tick(input logic [DataWidth-1:0] fr, input logic [DataWidth-1:0] fl,
                       input logic [DataWidth-1:0] lt, input logic [DataWidth-1:0] lb,
                       input logic bl, input logic br);
      item_type t;
      t = '{fr, fl, lt, lb, bl, br};
      send_item(t);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [DataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_reg(idx, data);
   endtask

   task automatic load_settings(input setting_type which);
      logic [DataWidth-1:0] val;
      for (int i = REG_FRONT_NEAR; i <= REG_FAST_TURN; i++) begin
         case (which)
            SET_ZERO: val = '0;
            SET_FULL: val = '1;
            SET_CROSSED: begin
               if (i == REG_FRONT_NEAR || i == REG_SIDE_NEAR)
                  val = DataWidth'($urandom_range(1000, 1));
               else if (i == REG_FRONT_FAR || i == REG_SIDE_FAR)
                  val = DataWidth'($urandom_range(2**DataWidth - 1, 60000));
               else
                  val = DataWidth'($urandom);
            end
            default: val = DataWidth'($urandom);
         endcase
         write_reg(CsrIdxWidth'(i), val);
      end
      write_reg(CsrIdxWidth'($urandom_range(2**CsrIdxWidth - 1, REG_FAST_TURN + 1)),
                DataWidth'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DataWidth-1:0] pick_reading(logic [DataWidth-1:0] near_lvl,
                                                         logic [DataWidth-1:0] far_lvl);
      case ($urandom_range(7, 0))
         0:       return '0;
         1:       return near_lvl;
         2:       return near_lvl + 1'b1;
         3:       return far_lvl;
         4:       return far_lvl - 1'b1;
         5:       return '1;
         default: return DataWidth'($urandom);
      endcase
   endfunction

   // Steer the floor and side readings so that the run ends only when asked.
   function automatic item_type make_tick(goal_type goal);
      item_type t;
      t.prox_front_right  = pick_reading(tracker.cfg.front_near_level,
                                         tracker.cfg.front_far_level);
      t.prox_front_left   = pick_reading(tracker.cfg.front_near_level,
                                         tracker.cfg.front_far_level);
      t.prox_left_top     = pick_reading(tracker.cfg.side_near_level, tracker.cfg.side_far_level);
      t.prox_left_bottom  = pick_reading(tracker.cfg.side_near_level, tracker.cfg.side_far_level);
      t.floor_left_black  = 1'($urandom);
      t.floor_right_black = 1'($urandom);
      case (tracker.cur_step)
         STEP_CHECK_FLOOR: begin
            if (goal != GOAL_DOCK) begin
               t.floor_left_black  = 1'b0;
               t.floor_right_black = 1'b0;
            end else if (!t.floor_left_black && !t.floor_right_black) begin
               t.floor_left_black  = 1'b1;
            end
         end
         STEP_CHECK_LT: begin
            if (goal == GOAL_LOST)
               t.prox_left_top = '0;
         end
         STEP_CHECK_LB_A: begin
            if (goal == GOAL_LOST)
               t.prox_left_bottom = '0;
            else if (t.prox_left_bottom == 0)
               t.prox_left_bottom = DataWidth'($urandom_range(2**DataWidth - 1, 1));
         end
         default: ;
      endcase
      return t;
   endfunction

   initial begin
      goal_type    ending;
      setting_type which;
      tracker = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_reg(CsrIdxWidth'($urandom_range(2**CsrIdxWidth - 1, REG_FAST_TURN + 1)),
                DataWidth'($urandom));
      csr_valid <= 1'b0;

      tick('0, '0, '0, '0, 1'b1, 1'b1);
      tick('1, '1, '1, '1, 1'b0, 1'b0);
      tick('1, 16'd7, 16'd3, 16'd9, 1'b1, 1'b0);
      tick('0, '1, '0, '1, 1'b0, 1'b1);
      tick('0, 16'd100, '1, '0, 1'b1, 1'b1);
      tick(16'd5, '1, '0, '0, 1'b0, 1'b0);
      tick('1, '0, '1, '1, 1'b1, 1'b0);
      tick('0, 16'd1, '0, '0, 1'b0, 1'b1);
      tick('0, '0, '1, '0, 1'b1, 1'b1);
      tick('1, '1, '0, '1, 1'b0, 1'b0);
      tick('0, '0, '0, '0, 1'b1, 1'b0);
      tick('1, '1, '1, '1, 1'b0, 1'b0);
      tick(16'd20000, '0, '0, '0, 1'b0, 1'b1);
      tick('0, 16'd20001, '0, '0, 1'b1, 1'b1);
      tick('1, '1, '1, '1, 1'b0, 1'b0);
      tick('1, '0, '1, '1, 1'b0, 1'b0);
      tick('1, '1, '0, '0, 1'b1, 1'b0);
      tick('0, '0, '0, '1, 1'b0, 1'b1);
      tick('1, '1, '1, '1, 1'b1, 1'b1);
      tick('0, '0, '0, '0, 1'b0, 1'b0);
      tick('0, '0, '0, '0, 1'b0, 1'b0);
      tick(16'd5000, '0, '0, '0, 1'b1, 1'b1);
      tick('0, 16'd4999, '0, '0, 1'b0, 1'b0);
      tick('0, '0, 16'd1, '0, 1'b0, 1'b1);
      tick('1, '1, '1, '1, 1'b1, 1'b0);

      for (int p = 1; p <= 5; p++) begin
         wait_drain();
         case (p)
            1:       which = SET_ZERO;
            2:       which = SET_FULL;
            4:       which = SET_CROSSED;
            default: which = SET_RANDOM;
         endcase
         load_settings(which);
         case (p % 4)
            1:       begin gap_pct = 52; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 52; end
            3:       begin gap_pct = 6;  stall_pct = 6;  end
            default: begin gap_pct = 0;  stall_pct = 0;  end
         endcase
         for (int n = 0; n < ROAM_TICKS; n++) begin
            // hold off the sender until the result channel has caught up
            if (p == 1 && n == ROAM_TICKS / 2)
               wait_drain();
            send_item(make_tick(GOAL_ROAM));
         end
      end

      ending = ($urandom_range(1, 0) != 0) ? GOAL_DOCK : GOAL_LOST;
      while (tracker.finished == STAT_RUNNING) send_item(make_tick(ending));
      repeat (12) send_item(make_tick(GOAL_ROAM));

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      tracker.close();
      if (tracker.faults == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[wall_follow_sequencer.f]
rtl/core/wfs_pkg.sv
rtl/core/wfs_step.sv
rtl/core/wall_follow_sequencer.sv
rtl/core/wfs_checker.sv
bench/wall_follow_sequencer_test.sv
